// ===== rtl/aasu_pkg.sv =====
`default_nettype none

package aasu_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int NUM_GR      = 6;

    // opcode codes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_ADC  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_SBB  = 3'd3;
    localparam logic [2:0] OP_DAD  = 3'd4;
    localparam logic [2:0] OP_LOAD = 3'd5;

    // source select codes
    localparam logic [3:0] SEL_MEM = 4'd6;
    localparam logic [3:0] SEL_ACC = 4'd7;
    localparam logic [3:0] SEL_IMM = 4'd8;

    // index of H and L in the register file
    localparam logic [2:0] GR_H = 3'd4;
    localparam logic [2:0] GR_L = 3'd5;

    typedef enum logic [2:0] {
        CLS_ADD,
        CLS_SUB,
        CLS_DAD,
        CLS_LOAD,
        CLS_NOP
    } op_class_t;

    typedef enum logic [1:0] {
        SRC_REG,
        SRC_ACC,
        SRC_EXT,
        SRC_NONE
    } src_kind_t;

    typedef struct packed {
        op_class_t   cls;
        logic        use_carry;
        src_kind_t   src_kind;
        logic [2:0]  reg_idx;
        logic [1:0]  pair;
        logic [7:0]  ext_byte;
        logic [15:0] stack_pointer;
    } item_t;

    typedef struct packed {
        logic sign;
        logic zero;
        logic aux_carry;
        logic parity;
        logic carry;
    } flags_t;

endpackage

`default_nettype wire

// ===== rtl/aasu_front.sv =====
`default_nettype none

module aasu_front (
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // opcode[2:0], source_select[6:3], memory_data[14:7],
    // immediate_byte[22:15], stack_pointer[38:23], zero pad[39]
    input  wire logic [aasu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output aasu_pkg::item_t                       q_item
);

    logic [2:0]  opcode;
    logic [3:0]  source_select;
    logic [7:0]  memory_data;
    logic [7:0]  immediate_byte;
    logic [15:0] stack_pointer;

    assign opcode         = s_axis_tdata[2:0];
    assign source_select  = s_axis_tdata[6:3];
    assign memory_data    = s_axis_tdata[14:7];
    assign immediate_byte = s_axis_tdata[22:15];
    assign stack_pointer  = s_axis_tdata[38:23];

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb begin
        q_item               = '0;
        q_item.reg_idx       = source_select[2:0];
        q_item.pair          = source_select[1:0];
        q_item.stack_pointer = stack_pointer;
        q_item.use_carry     = (opcode == aasu_pkg::OP_ADC) || (opcode == aasu_pkg::OP_SBB);
        q_item.ext_byte      = immediate_byte;

        priority if (source_select < aasu_pkg::SEL_MEM) begin
            q_item.src_kind = aasu_pkg::SRC_REG;
        end else if (source_select == aasu_pkg::SEL_MEM) begin
            q_item.src_kind = aasu_pkg::SRC_EXT;
            q_item.ext_byte = memory_data;
        end else if (source_select == aasu_pkg::SEL_ACC) begin
            q_item.src_kind = aasu_pkg::SRC_ACC;
        end else begin
            q_item.src_kind = aasu_pkg::SRC_EXT;
        end

        unique case (opcode)
            aasu_pkg::OP_ADD, aasu_pkg::OP_ADC: begin
                q_item.cls = aasu_pkg::CLS_ADD;
            end
            aasu_pkg::OP_SUB, aasu_pkg::OP_SBB: begin
                q_item.cls = aasu_pkg::CLS_SUB;
            end
            aasu_pkg::OP_DAD: begin
                q_item.cls = aasu_pkg::CLS_DAD;
            end
            aasu_pkg::OP_LOAD: begin
                q_item.cls = aasu_pkg::CLS_LOAD;
                // load into memory or past the accumulator writes nothing
                if (source_select == aasu_pkg::SEL_MEM || source_select >= aasu_pkg::SEL_IMM) begin
                    q_item.src_kind = aasu_pkg::SRC_NONE;
                end
            end
            default: begin
                q_item.cls = aasu_pkg::CLS_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/aasu_queue.sv =====
`default_nettype none

module aasu_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire aasu_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output aasu_pkg::item_t      head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aasu_pkg::item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aasu_exec.sv =====
`default_nettype none

module aasu_exec (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             q_valid,
    input  wire aasu_pkg::item_t                  q_item,
    output logic                                  q_pop,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [aasu_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic [7:0]       acc_reg, acc_next;
    logic [7:0]       gr_reg [aasu_pkg::NUM_GR];
    logic [7:0]       gr_next [aasu_pkg::NUM_GR];
    aasu_pkg::flags_t flags_reg, flags_next;

    logic                                 m_valid_reg, m_valid_next;
    logic [aasu_pkg::OUT_TDATA_W-1:0]     m_data_reg;

    logic [7:0]  src;
    logic        cin;
    logic [8:0]  add9, sub9;
    logic [4:0]  add_nib, sub_nib;
    logic [7:0]  res;
    logic [15:0] addend;
    logic [16:0] dad_sum;

    assign q_pop         = q_valid && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb begin
        unique case (q_item.src_kind)
            aasu_pkg::SRC_REG: begin
                unique case (q_item.reg_idx)
                    3'd0:    src = gr_reg[0];
                    3'd1:    src = gr_reg[1];
                    3'd2:    src = gr_reg[2];
                    3'd3:    src = gr_reg[3];
                    3'd4:    src = gr_reg[4];
                    3'd5:    src = gr_reg[5];
                    default: src = '0;
                endcase
            end
            aasu_pkg::SRC_ACC:  src = acc_reg;
            aasu_pkg::SRC_EXT:  src = q_item.ext_byte;
            default:            src = q_item.ext_byte;
        endcase

        unique case (q_item.pair)
            2'd0:    addend = {gr_reg[0], gr_reg[1]};
            2'd1:    addend = {gr_reg[2], gr_reg[3]};
            2'd2:    addend = {gr_reg[4], gr_reg[5]};
            default: addend = q_item.stack_pointer;
        endcase
    end

    assign cin     = q_item.use_carry & flags_reg.carry;
    assign add9    = {1'b0, acc_reg} + {1'b0, src} + 9'(cin);
    // borrow shows as bit 8 of the difference going negative
    assign sub9    = {1'b0, acc_reg} - {1'b0, src} - 9'(cin);
    assign add_nib = {1'b0, acc_reg[3:0]} + {1'b0, src[3:0]} + 5'(cin);
    assign sub_nib = {1'b0, acc_reg[3:0]} - {1'b0, src[3:0]} - 5'(cin);
    assign res     = (q_item.cls == aasu_pkg::CLS_SUB) ? sub9[7:0] : add9[7:0];
    assign dad_sum = {1'b0, gr_reg[aasu_pkg::GR_H], gr_reg[aasu_pkg::GR_L]} + {1'b0, addend};

    always_comb begin
        acc_next   = acc_reg;
        gr_next    = gr_reg;
        flags_next = flags_reg;

        unique case (q_item.cls)
            aasu_pkg::CLS_ADD, aasu_pkg::CLS_SUB: begin
                acc_next             = res;
                flags_next.sign      = res[7];
                flags_next.zero      = (res == '0);
                flags_next.parity    = ~^res;
                if (q_item.cls == aasu_pkg::CLS_SUB) begin
                    flags_next.carry     = sub9[8];
                    flags_next.aux_carry = sub_nib[4];
                end else begin
                    flags_next.carry     = add9[8];
                    flags_next.aux_carry = add_nib[4];
                end
            end
            aasu_pkg::CLS_DAD: begin
                gr_next[aasu_pkg::GR_H] = dad_sum[15:8];
                gr_next[aasu_pkg::GR_L] = dad_sum[7:0];
                flags_next.carry        = dad_sum[16];
            end
            aasu_pkg::CLS_LOAD: begin
                if (q_item.src_kind == aasu_pkg::SRC_ACC) begin
                    acc_next = q_item.ext_byte;
                end else if (q_item.src_kind == aasu_pkg::SRC_REG) begin
                    for (int i = 0; i < aasu_pkg::NUM_GR; i++) begin
                        if (q_item.reg_idx == 3'(i)) begin
                            gr_next[i] = q_item.ext_byte;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < aasu_pkg::NUM_GR; i++) begin
                gr_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                acc_reg   <= acc_next;
                flags_reg <= flags_next;
                gr_reg    <= gr_next;
            end
        end
    end

    // result word holds the state after the step
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= {3'b000, flags_next.carry, flags_next.parity, flags_next.aux_carry,
                           flags_next.zero, flags_next.sign,
                           gr_next[aasu_pkg::GR_H], gr_next[aasu_pkg::GR_L], acc_next};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/accumulator_add_sub_unit_top.sv =====
`default_nettype none

// channel   dir  ports            word
// s_axis    in   tvalid/tready    40-bit operation word
// m_axis    out  tvalid/tready    32-bit state and flags word
//
// one word per cycle sustained while m_axis is not stalled; a result reaches m_axis
// through the queue register and then the result register
// the executer updates accumulator, B..L and flags in the cycle it pops the queue
// aresetn clears accumulator, B..L, flags and queue pointers, no clearing pass
// a stalled m_axis side fills the queue (QUEUE_DEPTH words), then s_axis_tready drops

module accumulator_add_sub_unit_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // opcode[2:0], source_select[6:3], memory_data[14:7],
    // immediate_byte[22:15], stack_pointer[38:23], zero pad[39]
    input  wire logic [aasu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // accumulator_out[7:0], hl_pair_out[23:8], sign_flag[24], zero_flag[25],
    // aux_carry_flag[26], parity_flag[27], carry_flag[28], zero pad[31:29]
    output logic [aasu_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic            q_full;
    logic            q_push;
    aasu_pkg::item_t q_push_item;
    logic            q_pop;
    logic            q_valid;
    aasu_pkg::item_t q_head;

    aasu_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_push_item)
    );

    aasu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    aasu_exec u_exec (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/aasu_checker.sv =====
`default_nettype none

module aasu_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [aasu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // queue is empty straight after reset, so the input side is open
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("input not ready after reset");

    // a word taken while the result register is empty shows up after the queue and result registers
    a_word_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
        else $error("accepted word did not produce a result");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

endmodule

bind accumulator_add_sub_unit_top aasu_checker u_aasu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
